// ===== rtl/core/assert_macros.svh =====
// assertion macros used by the checker top level
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ABC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on the following clock edge
`define ABC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/abc_pkg.sv =====
// package for the allocation bounds checker: codes, constants and the entry type
// no dependencies
package abc_pkg;

  localparam int unsigned TableDepth = 1024;
  localparam int unsigned DeadKeep   = 256;
  localparam int unsigned SizeW      = 27;
  localparam int unsigned AddrW      = 64;
  localparam logic [AddrW-1:0] FirstBase = 64'd4096;
  localparam logic [SizeW-1:0] LimitReset = 27'd67108864;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_ACCESS  = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_LIMIT       = 4'd1,
    ST_FULL        = 4'd2,
    ST_NULL        = 4'd3,
    ST_INVALID     = 4'd4,
    ST_DEAD        = 4'd5,
    ST_BOUNDS      = 4'd6,
    ST_NOT_START   = 4'd7,
    ST_DOUBLE_FREE = 4'd8,
    ST_NOT_HEAP    = 4'd9
  } status_e;

  // one table entry as stored in memory
  typedef struct packed {
    logic [AddrW-1:0] base;
    logic [SizeW-1:0] size;
    logic             live;
    logic             heap;
  } entry_t;

endpackage

// ===== rtl/core/abc_table.sv =====
// allocation table memory: one write port, one registered read port
// depends on abc_pkg
module abc_table import abc_pkg::*; #(
  parameter int unsigned Depth = TableDepth
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  entry_t                   wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output entry_t                   rdata_o
);

  entry_t mem [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/core/allocation_bounds_checker.sv =====
// allocation bounds checker top level: control sequencer, registers, apb port
// depends on abc_pkg, abc_table, assert_macros.svh
//
//  channel | direction | payload
//  s_axis  | in        | tdata {heap_req, heap_flag, request_size, address, cmd}
//  m_axis  | out       | tdata {offset, result_address, status}
//  apb     | in/out    | byte_limit at address 0
//
// allocate goes from accept through the alloc state to the result; a refused allocate, a release
// of address zero, a null access and an invalid command go straight to the result
// release and access run a binary search, a read and a wait state per step, up to
// log2(entry count)+1 steps, then read the matched entry and decide
// compaction, when due, adds a read and a wait per entry for the split scan and the copy pass
// one item is in work at a time; s_axis_tready is low until the result is taken
// reset clears counters, sets bump pointer to FirstBase, restores limit; table needs no clearing
`include "assert_macros.svh"
module allocation_bounds_checker import abc_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TableDepth,
  parameter int unsigned DEAD_KEEP   = DeadKeep
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // cmd[1:0], address[65:2], request_size[92:66], heap_flag[93], heap_req[94], pad
  input  logic [95:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[3:0], result_address[67:4], offset[94:68], pad
  output logic [95:0]  m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [1:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW = IdxW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH_RD, S_SRCH_WT, S_FIND_RD, S_FIND_WT, S_DECIDE,
    S_SPLIT_RD, S_SPLIT_WT, S_COMP_RD, S_COMP_WT, S_ALLOC, S_OUT
  } state_e;

  state_e state_q;
  logic [SizeW-1:0] limit_q;
  logic [CntW-1:0]  count_q, dead_q;
  logic [SizeW-1:0] live_bytes_q;
  logic [AddrW-1:0] next_base_q;
  cmd_e             cmd_q;
  logic [AddrW-1:0] addr_q;
  logic [SizeW-1:0] size_q;
  logic             hflag_q, honly_q;
  logic [CntW-1:0]  lo_q, hi_q, split_q, seen_q, kept_q, idx_q;
  logic [3:0]       st_q;
  logic [AddrW-1:0] res_q;
  logic [SizeW-1:0] off_q;

  logic             we;
  logic [IdxW-1:0]  waddr, raddr;
  entry_t           wdata, rdata;
  logic [CntW-1:0]  mid;
  logic [AddrW-1:0] diff;
  logic [SizeW:0]   room;

  assign mid  = lo_q + ((hi_q - lo_q) >> 1);
  assign diff = addr_q - rdata.base;
  assign room = {1'b0, rdata.size} - {1'b0, diff[SizeW-1:0]};

  abc_table #(.Depth(TABLE_DEPTH)) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // apb port
  assign pready = 1'b1;
  assign prdata = {{(32-SizeW){1'b0}}, limit_q};

  // stream ports
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = {1'b0, off_q, res_q, st_q};

  // memory address and write select
  always_comb begin
    we    = 1'b0;
    waddr = idx_q[IdxW-1:0];
    wdata = rdata;
    raddr = idx_q[IdxW-1:0];
    unique case (state_q)
      S_SRCH_RD: raddr = mid[IdxW-1:0];
      // split walk reads the entry below the current index
      S_SPLIT_RD: raddr = idx_q[IdxW-1:0] - 1'b1;
      S_DECIDE: begin
        wdata.live = 1'b0;
        we = (cmd_q == CMD_RELEASE) && (lo_q != '0) && (diff == '0) && rdata.live &&
             !(honly_q && !rdata.heap);
      end
      S_COMP_WT: begin
        waddr = kept_q[IdxW-1:0];
        we = rdata.live || (idx_q >= split_q);
      end
      S_ALLOC: begin
        waddr = count_q[IdxW-1:0];
        wdata.base = (next_base_q == '0) ? FirstBase : next_base_q;
        wdata.size = size_q;
        wdata.live = 1'b1;
        wdata.heap = hflag_q;
        we = (count_q < CntW'(TABLE_DEPTH));
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      limit_q      <= LimitReset;
      count_q      <= '0;
      dead_q       <= '0;
      live_bytes_q <= '0;
      next_base_q  <= FirstBase;
      cmd_q        <= CMD_ALLOC;
      addr_q       <= '0;
      size_q       <= '0;
      hflag_q      <= 1'b0;
      honly_q      <= 1'b0;
      lo_q         <= '0;
      hi_q         <= '0;
      split_q      <= '0;
      seen_q       <= '0;
      kept_q       <= '0;
      idx_q        <= '0;
      st_q         <= ST_OK;
      res_q        <= '0;
      off_q        <= '0;
    end else begin
      if (psel && penable && pwrite && paddr == 2'd0) begin
        limit_q <= pwdata[SizeW-1:0];
      end
      unique case (state_q)
        S_IDLE: if (s_axis_tvalid) begin
          cmd_q   <= cmd_e'(s_axis_tdata[1:0]);
          addr_q  <= s_axis_tdata[65:2];
          size_q  <= s_axis_tdata[92:66];
          hflag_q <= s_axis_tdata[93];
          honly_q <= s_axis_tdata[94];
          st_q    <= ST_OK;
          res_q   <= '0;
          off_q   <= '0;
          lo_q    <= '0;
          hi_q    <= count_q;
          unique case (cmd_e'(s_axis_tdata[1:0]))
            CMD_ALLOC: begin
              if (s_axis_tdata[92:66] > limit_q ||
                  live_bytes_q > limit_q - s_axis_tdata[92:66]) begin
                st_q <= ST_LIMIT;
                state_q <= S_OUT;
              end else if (32'(dead_q) > 32'(2 * DEAD_KEEP)) begin
                idx_q <= count_q;
                seen_q <= '0;
                state_q <= S_SPLIT_RD;
              end else begin
                state_q <= S_ALLOC;
              end
            end
            CMD_RELEASE: state_q <= (s_axis_tdata[65:2] == '0) ? S_OUT : S_SRCH_RD;
            CMD_ACCESS: begin
              if (s_axis_tdata[65:2] == '0) begin
                st_q <= ST_NULL;
                state_q <= S_OUT;
              end else begin
                state_q <= S_SRCH_RD;
              end
            end
            default: begin
              st_q <= ST_INVALID;
              state_q <= S_OUT;
            end
          endcase
        end
        // binary search: read the middle entry
        S_SRCH_RD: begin
          if (lo_q < hi_q) begin
            idx_q <= mid;
            state_q <= S_SRCH_WT;
          end else if (lo_q == '0) begin
            st_q <= (cmd_q == CMD_RELEASE) ? ST_NOT_START : ST_INVALID;
            state_q <= S_OUT;
          end else begin
            idx_q <= lo_q - 1'b1;
            state_q <= S_FIND_RD;
          end
        end
        S_SRCH_WT: begin
          if (rdata.base <= addr_q) lo_q <= idx_q + 1'b1;
          else hi_q <= idx_q;
          state_q <= S_SRCH_RD;
        end
        S_FIND_RD: state_q <= S_FIND_WT;
        S_FIND_WT: state_q <= S_DECIDE;
        // checks on the matched entry
        S_DECIDE: begin
          state_q <= S_OUT;
          if (diff > {{(AddrW-SizeW){1'b0}}, rdata.size}) begin
            st_q <= (cmd_q == CMD_RELEASE) ? ST_NOT_START : ST_INVALID;
          end else if (cmd_q == CMD_RELEASE) begin
            if (diff != '0) st_q <= ST_NOT_START;
            else if (!rdata.live) st_q <= ST_DOUBLE_FREE;
            else if (honly_q && !rdata.heap) st_q <= ST_NOT_HEAP;
            else begin
              dead_q <= dead_q + 1'b1;
              live_bytes_q <= live_bytes_q - rdata.size;
            end
          end else begin
            res_q <= rdata.base;
            off_q <= diff[SizeW-1:0];
            if (!rdata.live) st_q <= ST_DEAD;
            else if ({1'b0, size_q} > room || room[SizeW]) st_q <= ST_BOUNDS;
          end
        end
        // compaction: find the split below the newest kept dead entries
        S_SPLIT_RD: begin
          if (idx_q > '0 && 32'(seen_q) < 32'(DEAD_KEEP)) begin
            idx_q <= idx_q - 1'b1;
            state_q <= S_SPLIT_WT;
          end else begin
            split_q <= idx_q;
            idx_q <= '0;
            kept_q <= '0;
            state_q <= S_COMP_RD;
          end
        end
        S_SPLIT_WT: begin
          if (!rdata.live) seen_q <= seen_q + 1'b1;
          state_q <= S_SPLIT_RD;
        end
        // compaction: copy entries down
        S_COMP_RD: state_q <= (idx_q < count_q) ? S_COMP_WT : S_ALLOC;
        S_COMP_WT: begin
          if (rdata.live || idx_q >= split_q) kept_q <= kept_q + 1'b1;
          else if (dead_q != '0) dead_q <= dead_q - 1'b1;
          idx_q <= idx_q + 1'b1;
          if (idx_q + 1'b1 >= count_q) begin
            count_q <= (rdata.live || idx_q >= split_q) ? kept_q + 1'b1 : kept_q;
            state_q <= S_ALLOC;
          end else begin
            state_q <= S_COMP_RD;
          end
        end
        S_ALLOC: begin
          state_q <= S_OUT;
          if (count_q >= CntW'(TABLE_DEPTH)) begin
            st_q <= ST_FULL;
          end else begin
            count_q <= count_q + 1'b1;
            res_q <= wdata.base;
            next_base_q <= wdata.base +
              (({{(AddrW-SizeW){1'b0}}, size_q} + 64'd31) & ~64'd15);
            live_bytes_q <= live_bytes_q + size_q;
          end
        end
        S_OUT: if (m_axis_tready) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `ABC_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CntW'(TABLE_DEPTH), "entry count over depth")
  `ABC_ASSERT(a_dead_bound, clk_i, rst_ni, dead_q <= count_q, "dead count over entry count")
  `ABC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

endmodule

// ===== test/testbench.sv =====
// testbench for allocation_bounds_checker: stream items in, results checked against a predictor
// depends on abc_pkg and the allocation_bounds_checker rtl
`timescale 1ns / 100ps
module testbench;
  import abc_pkg::*;

  localparam int unsigned WatchdogLimit = 40000;
  localparam logic [SizeW-1:0] LimitMax = 27'd67108864;

  // packed from the highest bit down, so cmd lands in the lowest bits
  typedef struct packed {
    logic             heap_req;
    logic             heap_flag;
    logic [SizeW-1:0] request_size;
    logic [AddrW-1:0] address;
    cmd_e             cmd;
  } request_t;

  typedef struct packed {
    logic [SizeW-1:0] offset;
    logic [AddrW-1:0] result_address;
    status_e          status;
  } verdict_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // cmd, address, request_size, heap_flag, heap_req, pad
  logic [95:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // status, result_address, offset, pad
  logic [95:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  allocation_bounds_checker dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #6 clk_i = ~clk_i;

  // predictor state
  logic [AddrW-1:0] tbl_base [TableDepth];
  logic [SizeW-1:0] tbl_size [TableDepth];
  logic             tbl_live [TableDepth];
  logic             tbl_heap [TableDepth];
  int unsigned      n_entries = 0;
  int unsigned      n_dead = 0;
  int unsigned      bytes_live = 0;
  logic [AddrW-1:0] bump_ptr = FirstBase;
  int unsigned      limit_bytes = LimitMax;

  request_t         pending_q [$];
  verdict_t         verdict_q [$];
  logic [AddrW-1:0] known_base [$];
  int unsigned      known_size [$];
  int               fail_count = 0;
  bit               quiet = 1'b0;
  bit               in_fire = 1'b0;
  int               in_gap = 0;
  int unsigned      idle_cycles = 0;

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // drop the older dead entries, keeping the newest DeadKeep of them
  task automatic compact_table();
    int unsigned split, seen, kept;
    split = n_entries;
    seen = 0;
    kept = 0;
    while (split > 0 && seen < DeadKeep) begin
      split--;
      if (!tbl_live[split]) seen++;
    end
    for (int unsigned i = 0; i < n_entries; i++) begin
      if (i >= split || tbl_live[i]) begin
        tbl_base[kept] = tbl_base[i];
        tbl_size[kept] = tbl_size[i];
        tbl_live[kept] = tbl_live[i];
        tbl_heap[kept] = tbl_heap[i];
        kept++;
      end else if (n_dead > 0) begin
        n_dead--;
      end
    end
    n_entries = kept;
  endtask

  // last entry with base at or below the address, one past the end allowed
  function automatic int lookup_entry(logic [AddrW-1:0] addr);
    int unsigned lo, hi, mid;
    lo = 0;
    hi = n_entries;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (tbl_base[mid] <= addr) lo = mid + 1;
      else hi = mid;
    end
    if (lo == 0) return -1;
    if (addr - tbl_base[lo-1] > 64'(tbl_size[lo-1])) return -1;
    return lo - 1;
  endfunction

  task automatic predict_verdict(input request_t rq, output verdict_t vd);
    int hit;
    logic [AddrW-1:0] off;
    vd = '{status: ST_OK, result_address: '0, offset: '0};
    case (rq.cmd)
      CMD_ALLOC: begin
        if (rq.request_size > limit_bytes || bytes_live > limit_bytes - rq.request_size) begin
          vd.status = ST_LIMIT;
        end else begin
          if (n_dead > 2 * DeadKeep) compact_table();
          if (n_entries >= TableDepth) begin
            vd.status = ST_FULL;
          end else begin
            if (bump_ptr == 0) bump_ptr = FirstBase;
            tbl_base[n_entries] = bump_ptr;
            tbl_size[n_entries] = rq.request_size;
            tbl_live[n_entries] = 1'b1;
            tbl_heap[n_entries] = rq.heap_flag;
            n_entries++;
            vd.result_address = bump_ptr;
            known_base.push_back(bump_ptr);
            known_size.push_back(rq.request_size);
            bump_ptr += (64'(rq.request_size) + 64'd31) & ~64'd15;
            bytes_live += rq.request_size;
          end
        end
      end
      CMD_RELEASE: begin
        if (rq.address != 0) begin
          hit = lookup_entry(rq.address);
          if (hit < 0 || tbl_base[hit] != rq.address) vd.status = ST_NOT_START;
          else if (!tbl_live[hit]) vd.status = ST_DOUBLE_FREE;
          else if (rq.heap_req && !tbl_heap[hit]) vd.status = ST_NOT_HEAP;
          else begin
            tbl_live[hit] = 1'b0;
            n_dead++;
            bytes_live -= tbl_size[hit];
          end
        end
      end
      CMD_ACCESS: begin
        if (rq.address == 0) begin
          vd.status = ST_NULL;
        end else begin
          hit = lookup_entry(rq.address);
          if (hit < 0) begin
            vd.status = ST_INVALID;
          end else begin
            off = rq.address - tbl_base[hit];
            vd.result_address = tbl_base[hit];
            vd.offset = off[SizeW-1:0];
            if (!tbl_live[hit]) vd.status = ST_DEAD;
            else if (64'(rq.request_size) > 64'(tbl_size[hit]) - off) vd.status = ST_BOUNDS;
          end
        end
      end
      default: vd.status = ST_INVALID;
    endcase
  endtask

  task automatic queue_item(cmd_e c, logic [AddrW-1:0] a, logic [SizeW-1:0] s,
                            logic hf, logic ho);
    request_t rq;
    verdict_t vd;
    rq = '{cmd: c, address: a, request_size: s, heap_flag: hf, heap_req: ho};
    predict_verdict(rq, vd);
    pending_q.push_back(rq);
    verdict_q.push_back(vd);
  endtask

  task automatic queue_random_item();
    int r, k;
    cmd_e c;
    logic [AddrW-1:0] a;
    logic [SizeW-1:0] s;
    r = $urandom_range(0, 99);
    c = r < 40 ? CMD_ALLOC : r < 70 ? CMD_RELEASE : r < 96 ? CMD_ACCESS : CMD_NONE;
    r = $urandom_range(0, 99);
    if (r < 80) s = SizeW'($urandom_range(0, 256));
    else if (r < 95) s = SizeW'($urandom_range(0, 70000));
    else s = SizeW'($urandom_range(0, LimitMax));
    r = $urandom_range(0, 99);
    if (known_base.size() > 0 && r < 70) begin
      k = $urandom_range(0, known_base.size() - 1);
      a = known_base[k];
      if (c == CMD_ACCESS) begin
        a += 64'($urandom_range(0, known_size[k] + 2));
        s = SizeW'($urandom_range(0, known_size[k] + 2));
      end else if ($urandom_range(0, 9) == 0) begin
        a += 64'($urandom_range(1, 8));
      end
    end else if (r < 88) begin
      a = {$urandom, $urandom};
    end else begin
      a = '0;
    end
    queue_item(c, a, s, 1'($urandom), 1'($urandom));
  endtask

  // block is idle once every item is taken and every result is back
  task automatic wait_drained();
    wait (pending_q.size() == 0 && verdict_q.size() == 0 && !s_axis_tvalid);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= '0;
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    limit_bytes = value[SizeW-1:0];
  endtask

  // driver: present items from the pending queue at the falling edge
  always @(negedge clk_i) begin
    m_axis_tready <= quiet ? 1'b1 : (draw_gap() == 0);
    if (s_axis_tvalid && !in_fire) begin
      // hold the item until it is taken
    end else if (in_gap > 0) begin
      in_gap <= in_gap - 1;
      s_axis_tvalid <= 1'b0;
    end else if (pending_q.size() > 0 && rst_ni) begin
      s_axis_tdata <= {1'b0, pending_q.pop_front()};
      s_axis_tvalid <= 1'b1;
      in_gap <= draw_gap();
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // monitor: compare each result with the oldest expectation
  always @(posedge clk_i) begin
    verdict_t got, want;
    in_fire <= s_axis_tvalid && s_axis_tready;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[94:0];
      if (verdict_q.size() == 0) begin
        $error("result with nothing expected: %h", got);
        fail_count++;
      end else begin
        want = verdict_q.pop_front();
        if (got.status != want.status) begin
          $error("status expected %0d actual %0d", want.status, got.status);
          fail_count++;
        end
        if (got.result_address != want.result_address) begin
          $error("result_address expected %h actual %h", want.result_address,
                 got.result_address);
          fail_count++;
        end
        if (got.offset != want.offset) begin
          $error("offset expected %0d actual %0d", want.offset, got.offset);
          fail_count++;
        end
      end
    end
    if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
        verdict_q.size() == 0) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [AddrW-1:0] b0, b1;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty table, null, misses, lifetime and bounds
    queue_item(CMD_ACCESS, '0, 27'd4, 1'b0, 1'b0);
    queue_item(CMD_ACCESS, FirstBase, 27'd1, 1'b0, 1'b0);
    queue_item(CMD_RELEASE, '0, '0, 1'b0, 1'b1);
    queue_item(CMD_RELEASE, 64'd1234, '0, 1'b0, 1'b0);
    queue_item(CMD_ALLOC, '0, 27'd0, 1'b1, 1'b0);
    b0 = known_base[$];
    queue_item(CMD_ALLOC, '0, 27'd100, 1'b0, 1'b0);
    b1 = known_base[$];
    queue_item(CMD_ACCESS, b1, 27'd100, 1'b0, 1'b0);
    queue_item(CMD_ACCESS, b1 + 100, 27'd0, 1'b0, 1'b0);
    queue_item(CMD_ACCESS, b1 + 50, 27'd60, 1'b0, 1'b0);
    queue_item(CMD_ACCESS, b1 + 101, 27'd0, 1'b0, 1'b0);
    queue_item(CMD_ACCESS, b0, 27'd1, 1'b0, 1'b0);
    queue_item(CMD_RELEASE, b1 + 4, '0, 1'b0, 1'b0);
    queue_item(CMD_RELEASE, b1, '0, 1'b0, 1'b1);
    queue_item(CMD_RELEASE, b1, '0, 1'b1, 1'b0);
    queue_item(CMD_RELEASE, b1, '0, 1'b0, 1'b0);
    queue_item(CMD_ACCESS, b1 + 8, 27'd2, 1'b0, 1'b0);
    queue_item(CMD_RELEASE, b0, '0, 1'b0, 1'b1);
    queue_item(CMD_ALLOC, '0, LimitMax, 1'b1, 1'b1);
    queue_item(CMD_ALLOC, '0, 27'd1, 1'b0, 1'b0);
    queue_item(CMD_RELEASE, known_base[$], '0, 1'b0, 1'b1);
    queue_item(CMD_NONE, {64{1'b1}}, {SizeW{1'b1}}, 1'b1, 1'b1);
    queue_item(CMD_ACCESS, {64{1'b1}}, '0, 1'b0, 1'b0);
    wait_drained();

    repeat (300) queue_random_item();
    wait_drained();

    // zero limit: no allocation with a nonzero size fits
    write_limit(32'd0);
    queue_item(CMD_ALLOC, '0, 27'd0, 1'b0, 1'b0);
    queue_item(CMD_ALLOC, '0, 27'd1, 1'b0, 1'b0);
    repeat (50) queue_random_item();
    wait_drained();

    write_limit(32'd5000);
    quiet = 1'b1;
    repeat (150) queue_random_item();
    wait_drained();
    quiet = 1'b0;

    // full limit again, mixed traffic
    write_limit(32'(LimitMax));
    repeat (276) queue_random_item();
    wait_drained();

    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/abc_pkg.sv
rtl/core/abc_table.sv
rtl/core/allocation_bounds_checker.sv
test/testbench.sv
